>>> design/aarm_pkg.sv
package aarm_pkg;

	localparam int unsigned TW         = 16;
	localparam int unsigned CFG_W      = 13;
	localparam int unsigned IN_W       = 3 * TW;
	localparam int unsigned RW         = 16;
	localparam int unsigned OUT_W      = 9 * RW;
	localparam int unsigned SUM_W      = 32;
	localparam int unsigned ROOT_W     = 16;
	localparam int unsigned SQ_REM_W   = SUM_W;
	localparam int unsigned SQ_CAND_W  = 34;
	localparam int unsigned DIV_REM_W  = 30;
	localparam int unsigned DIV_CMP_W  = 32;
	localparam int unsigned Q_W        = 16;
	localparam int unsigned U_W        = 16;
	localparam int unsigned ANG_W      = 35;
	localparam int unsigned Z_W        = 33;
	localparam int unsigned XY_W       = 34;
	localparam int unsigned S_W        = 18;
	localparam int unsigned OMC_W      = 19;
	localparam int unsigned ATAN_N     = 30;
	localparam int unsigned CORDIC_STEPS_DEF = 16;

	localparam logic [CFG_W-1:0] LIMIT_RST = CFG_W'(8);
	localparam logic [Q_W-1:0]   ONE_Q14   = Q_W'(16384);

	localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sh026DD3B6A;

	typedef struct packed {
		logic [SQ_REM_W-1:0]  rem;
		logic [ROOT_W-1:0]    root;
		logic [2:0][TW-1:0]   th;
	} sq_t;

	typedef struct packed {
		logic [2:0][DIV_REM_W-1:0] rem;
		logic [2:0][Q_W-1:0]       q;
		logic [2:0]                neg;
		logic [ROOT_W-1:0]         phi;
		logic                      ident;
		logic                      flip;
		logic signed [Z_W-1:0]     z;
	} dv_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [2:0][U_W-1:0]    u;
		logic                   ident;
		logic                   flip;
	} cd_t;

	// floor(atan(2^-i) * 2^30)
	function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
		logic [31:0] v;
		unique case (idx)
			0:  v = 32'h3243F6A8;
			1:  v = 32'h1DAC6705;
			2:  v = 32'h0FADBAFC;
			3:  v = 32'h07F56EA6;
			4:  v = 32'h03FEAB76;
			5:  v = 32'h01FFD55B;
			6:  v = 32'h00FFFAAA;
			7:  v = 32'h007FFF55;
			8:  v = 32'h003FFFEA;
			9:  v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			24: v = 32'h0000003F;
			25: v = 32'h0000001F;
			26: v = 32'h0000000F;
			27: v = 32'h00000007;
			28: v = 32'h00000003;
			29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return $signed({1'b0, v});
	endfunction

endpackage

>>> design/aarm_sqrt_cell.sv
module aarm_sqrt_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  aarm_pkg::sq_t in_d,
	output logic          out_valid,
	output aarm_pkg::sq_t out_d
);
	import aarm_pkg::*;

	logic [SQ_CAND_W-1:0] cand;
	sq_t                  nxt;

	// try root bit BIT: rem holds S - root^2
	always_comb begin
		cand = (SQ_CAND_W'(in_d.root) << (BIT + 1)) | (SQ_CAND_W'(1) << (2 * BIT));
		nxt  = in_d;
		if ({{(SQ_CAND_W - SQ_REM_W){1'b0}}, in_d.rem} >= cand) begin
			nxt.rem  = in_d.rem - cand[SQ_REM_W-1:0];
			nxt.root = in_d.root | (ROOT_W'(1) << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

>>> design/aarm_div_cell.sv
module aarm_div_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  aarm_pkg::dv_t in_d,
	output logic          out_valid,
	output aarm_pkg::dv_t out_d
);
	import aarm_pkg::*;

	logic [DIV_CMP_W-1:0] dsh;
	dv_t                  nxt;

	// one quotient bit for all three lanes
	always_comb begin
		dsh = DIV_CMP_W'(in_d.phi) << BIT;
		nxt = in_d;
		for (int l = 0; l < 3; l++) begin
			if ({{(DIV_CMP_W - DIV_REM_W){1'b0}}, in_d.rem[l]} >= dsh) begin
				nxt.rem[l] = in_d.rem[l] - dsh[DIV_REM_W-1:0];
				nxt.q[l]   = in_d.q[l] | (Q_W'(1) << BIT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

>>> design/aarm_cordic_cell.sv
module aarm_cordic_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  aarm_pkg::cd_t in_d,
	output logic          out_valid,
	output aarm_pkg::cd_t out_d
);
	import aarm_pkg::*;

	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic signed [Z_W-1:0]  at;
	cd_t                    nxt;

	// rotation mode micro-rotation, arithmetic shifts floor
	always_comb begin
		dx  = in_d.y >>> STEP;
		dy  = in_d.x >>> STEP;
		at  = atan_q30(STEP);
		nxt = in_d;
		if (!in_d.z[Z_W-1]) begin
			nxt.x = in_d.x - dx;
			nxt.y = in_d.y + dy;
			nxt.z = in_d.z - at;
		end else begin
			nxt.x = in_d.x + dx;
			nxt.y = in_d.y - dy;
			nxt.z = in_d.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

>>> design/aarm_matrix.sv
module aarm_matrix (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [aarm_pkg::S_W-1:0]     s,
	input  logic signed [aarm_pkg::OMC_W-1:0]   omc,
	input  logic [2:0][aarm_pkg::U_W-1:0]       u,
	input  logic                                in_ident,
	output logic                                out_valid,
	output logic                                out_ident,
	output logic [8:0][aarm_pkg::RW-1:0]        r
);
	import aarm_pkg::*;

	localparam int unsigned PP_W  = 2 * U_W;
	localparam int unsigned SU_W  = S_W + U_W;
	localparam int unsigned MD_W  = OMC_W + PP_W;
	localparam int unsigned ACC_W = 54;
	localparam logic signed [ACC_W-1:0] ONE_Q42 = ACC_W'(64'd1 << 42);
	localparam logic signed [ACC_W-1:0] RND     = ACC_W'(64'd1 << 27);
	localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(16384);
	localparam logic signed [ACC_W-1:0] SAT_LO  = -ACC_W'(16384);

	function automatic logic [RW-1:0] rnd_clamp(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		t = (acc + RND) >>> 28;
		if (t > SAT_HI) begin
			return SAT_HI[RW-1:0];
		end else if (t < SAT_LO) begin
			return SAT_LO[RW-1:0];
		end
		return t[RW-1:0];
	endfunction

	// stage 4: squares, cross products, s*u
	logic signed [PP_W-1:0]  sq_s4 [3];
	logic signed [PP_W-1:0]  pr01_s4, pr02_s4, pr12_s4;
	logic signed [SU_W-1:0]  su_s4 [3];
	logic signed [OMC_W-1:0] omc_s4;
	logic                    ident_s4, v_s4;

	// stage 5: products with 1 - cos
	logic signed [MD_W-1:0]  md_s5 [3];
	logic signed [MD_W-1:0]  mo01_s5, mo02_s5, mo12_s5;
	logic signed [SU_W-1:0]  su_s5 [3];
	logic                    ident_s5, v_s5;

	logic signed [ACC_W-1:0] acc [9];
	logic signed [ACC_W-1:0] sh [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= $signed(u[i]) * $signed(u[i]);
				su_s4[i] <= s * $signed(u[i]);
			end
			pr01_s4  <= $signed(u[0]) * $signed(u[1]);
			pr02_s4  <= $signed(u[0]) * $signed(u[2]);
			pr12_s4  <= $signed(u[1]) * $signed(u[2]);
			omc_s4   <= omc;
			ident_s4 <= in_ident;

			for (int i = 0; i < 3; i++) begin
				md_s5[i] <= omc_s4 * sq_s4[i];
				su_s5[i] <= su_s4[i];
			end
			mo01_s5  <= omc_s4 * pr01_s4;
			mo02_s5  <= omc_s4 * pr02_s4;
			mo12_s5  <= omc_s4 * pr12_s4;
			ident_s5 <= ident_s4;
		end
	end

	// K*K diag is -(sum of the other two squares), off-diag u_i*u_j
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i] = ACC_W'(su_s5[i]) <<< 14;
		end
		acc[0] = ONE_Q42 - ACC_W'(md_s5[1]) - ACC_W'(md_s5[2]);
		acc[1] = ACC_W'(mo01_s5) - sh[2];
		acc[2] = ACC_W'(mo02_s5) + sh[1];
		acc[3] = ACC_W'(mo01_s5) + sh[2];
		acc[4] = ONE_Q42 - ACC_W'(md_s5[0]) - ACC_W'(md_s5[2]);
		acc[5] = ACC_W'(mo12_s5) - sh[0];
		acc[6] = ACC_W'(mo02_s5) - sh[1];
		acc[7] = ACC_W'(mo12_s5) + sh[0];
		acc[8] = ONE_Q42 - ACC_W'(md_s5[0]) - ACC_W'(md_s5[1]);
		for (int e = 0; e < 9; e++) begin
			r[e] = rnd_clamp(acc[e]);
		end
	end

	assign out_valid = v_s5;
	assign out_ident = ident_s5;

endmodule

>>> design/axis_angle_to_rotation_matrix.sv
// Rotation vector to 3x3 rotation matrix (Rodrigues / SO(3) exp map).
//
// Input stream s_*: one beat carries theta_x, theta_y, theta_z (signed Q3.13).
// Output stream m_*: one beat carries the nine matrix entries in Q1.14,
// saturated to +/-1, plus the identity flag in m_tuser.
// Config channel cfg_*: writes small_angle_limit (Q3.13); always ready.
// Write it only while no beat is in flight.
//
// Fully pipelined as a row of cells: 16 square-root cells (one root bit each),
// 16 divider cells (one quotient bit per cell, three lanes for the unit axis),
// CORDIC_STEPS CORDIC cells, then the matrix multiply stages.
// It takes one beat per cycle while s_tready is high.
// The chain advances on a common enable; when the receiver stalls with a
// result held in the output register, the chain still moves while its last
// stage is empty, then holds and s_tready drops.
// Reset clears all valid flags and sets the limit to 8; the pipeline
// contents are not cleared.
module axis_angle_to_rotation_matrix #(
	parameter int unsigned CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [aarm_pkg::IN_W-1:0]     s_tdata,   // theta_x, theta_y, theta_z
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [aarm_pkg::OUT_W-1:0]    m_tdata,   // r00 r01 r02 r10 r11 r12 r20 r21 r22
	output logic [0:0]                    m_tuser,   // is_identity
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [aarm_pkg::CFG_W-1:0]    cfg_data   // small_angle_limit
);
	import aarm_pkg::*;

	logic en;

	// limit register
	logic [CFG_W-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// stage 1: squares
	logic [2:0][SUM_W-1:0] sqr_s1;
	logic [2:0][TW-1:0]    th_s1;
	logic                  v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				sqr_s1[l] <= $signed(s_tdata[l*TW +: TW]) * $signed(s_tdata[l*TW +: TW]);
				th_s1[l]  <= s_tdata[l*TW +: TW];
			end
		end
	end

	// square-root chain, MSB first
	sq_t  sq_d [ROOT_W+1];
	logic sq_v [ROOT_W+1];

	always_comb begin
		sq_d[0].rem  = sqr_s1[0] + sqr_s1[1] + sqr_s1[2];
		sq_d[0].root = '0;
		sq_d[0].th   = th_s1;
		sq_v[0]      = v_s1;
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		aarm_sqrt_cell #(.BIT(ROOT_W - 1 - k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sq_v[k]),
			.in_d      (sq_d[k]),
			.out_valid (sq_v[k+1]),
			.out_d     (sq_d[k+1])
		);
	end

	// stage 2: angle fold, identity test, dividends
	logic [ROOT_W-1:0]       phi;
	logic signed [ANG_W-1:0] ang_w, ang_f;
	logic                    flip;
	logic [TW-1:0]           mag [3];
	dv_t                     dv_nxt;
	dv_t                     dv_d [Q_W+1];
	logic                    dv_v [Q_W+1];

	always_comb begin
		phi   = sq_d[ROOT_W].root;
		ang_w = ANG_W'(phi) << 17;
		if (ang_w > PI_Q30) begin
			ang_w = ang_w - TWO_PI_Q30;
		end
		flip  = 1'b0;
		ang_f = ang_w;
		if (ang_w > HALF_PI_Q30) begin
			ang_f = ang_w - PI_Q30;
			flip  = 1'b1;
		end else if (ang_w < -HALF_PI_Q30) begin
			ang_f = ang_w + PI_Q30;
			flip  = 1'b1;
		end
		for (int l = 0; l < 3; l++) begin
			mag[l]         = sq_d[ROOT_W].th[l][TW-1] ? TW'(-sq_d[ROOT_W].th[l])
			                                          : sq_d[ROOT_W].th[l];
			dv_nxt.rem[l]  = (DIV_REM_W'(mag[l]) << 14) + DIV_REM_W'(phi >> 1);
			dv_nxt.q[l]    = '0;
			dv_nxt.neg[l]  = sq_d[ROOT_W].th[l][TW-1];
		end
		dv_nxt.phi   = phi;
		dv_nxt.ident = (phi == '0) || (phi < ROOT_W'(limit_q));
		dv_nxt.flip  = flip;
		dv_nxt.z     = ang_f[Z_W-1:0];
	end

	logic v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= sq_v[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d[0] <= dv_nxt;
		end
	end

	assign dv_v[0] = v_s2;

	// divider chain: u = round(|theta| * 2^14 / phi)
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		aarm_div_cell #(.BIT(Q_W - 1 - k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv_v[k]),
			.in_d      (dv_d[k]),
			.out_valid (dv_v[k+1]),
			.out_d     (dv_d[k+1])
		);
	end

	// CORDIC chain
	cd_t           cd_d [CORDIC_STEPS+1];
	logic          cd_v [CORDIC_STEPS+1];
	logic [Q_W-1:0] qc [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qc[l]         = (dv_d[Q_W].q[l] > ONE_Q14) ? ONE_Q14 : dv_d[Q_W].q[l];
			cd_d[0].u[l]  = dv_d[Q_W].neg[l] ? U_W'(-qc[l]) : U_W'(qc[l]);
		end
		cd_d[0].x     = CORDIC_GAIN;
		cd_d[0].y     = '0;
		cd_d[0].z     = dv_d[Q_W].z;
		cd_d[0].ident = dv_d[Q_W].ident;
		cd_d[0].flip  = dv_d[Q_W].flip;
		cd_v[0]       = dv_v[Q_W];
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		aarm_cordic_cell #(.STEP(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cd_v[k]),
			.in_d      (cd_d[k]),
			.out_valid (cd_v[k+1]),
			.out_d     (cd_d[k+1])
		);
	end

	// stage 3: sin, 1 - cos in Q1.14
	logic signed [XY_W-1:0]  xf, yf, xr, yr;
	logic signed [S_W-1:0]   s_s3;
	logic signed [OMC_W-1:0] omc_s3;
	logic [2:0][U_W-1:0]     u_s3;
	logic                    ident_s3, v_s3;

	always_comb begin
		xf = cd_d[CORDIC_STEPS].flip ? -cd_d[CORDIC_STEPS].x : cd_d[CORDIC_STEPS].x;
		yf = cd_d[CORDIC_STEPS].flip ? -cd_d[CORDIC_STEPS].y : cd_d[CORDIC_STEPS].y;
		xr = (xf + XY_W'(32768)) >>> 16;
		yr = (yf + XY_W'(32768)) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= cd_v[CORDIC_STEPS];
		end
	end

	// cos goes negative past pi/2, keep its sign when narrowing
	always_ff @(posedge clk) begin
		if (en) begin
			s_s3     <= yr[S_W-1:0];
			omc_s3   <= OMC_W'(ONE_Q14) - OMC_W'(xr);
			u_s3     <= cd_d[CORDIC_STEPS].u;
			ident_s3 <= cd_d[CORDIC_STEPS].ident;
		end
	end

	// matrix stages
	logic                mat_v, mat_ident;
	logic [8:0][RW-1:0]  mat_r;

	aarm_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.s         (s_s3),
		.omc       (omc_s3),
		.u         (u_s3),
		.in_ident  (ident_s3),
		.out_valid (mat_v),
		.out_ident (mat_ident),
		.r         (mat_r)
	);

	// output register
	logic               load;
	logic               out_v_q;
	logic [8:0][RW-1:0] r_q;
	logic               ident_q;

	assign en       = m_tready || !out_v_q || !mat_v;
	assign load     = mat_v && (m_tready || !out_v_q);
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ident_q <= mat_ident;
			for (int e = 0; e < 9; e++) begin
				if (mat_ident) begin
					r_q[e] <= (e % 4 == 0) ? RW'(ONE_Q14) : '0;
				end else begin
					r_q[e] <= mat_r[e];
				end
			end
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = r_q;
	assign m_tuser[0] = ident_q;

endmodule

>>> design/aarm_checker.sv
module aarm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata,
	input logic [0:0]   m_tuser
);

	// identity beat carries exactly the unit matrix
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[15:0] == 16'd16384 && m_tdata[79:64] == 16'd16384 &&
			m_tdata[143:128] == 16'd16384 && m_tdata[63:16] == 48'd0 &&
			m_tdata[127:80] == 48'd0)
		else $error("identity beat with wrong entries");

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed under stall");

	// no beat out of reset
	a_rst: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("m_tvalid high in reset");

	// entries saturate at +/-1
	for (genvar e = 0; e < 9; e++) begin : g_rng
		a_range: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid |-> $signed(m_tdata[e*16 +: 16]) <= 16'sd16384 &&
				$signed(m_tdata[e*16 +: 16]) >= -16'sd16384)
			else $error("matrix entry out of range");
	end

endmodule

bind axis_angle_to_rotation_matrix aarm_checker u_aarm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
